/* rtl/pcsp_pkg.sv */
// Shared types, constants and helper functions of the pixel color pipeline.
package pcsp_pkg;

   localparam int TABLE_DEPTH    = 4096;
   localparam int FRAC_BITS      = 12;
   localparam int COEF_FRAC_BITS = 14;

   localparam int COMP_W   = 16;
   localparam int ALPHA_W  = 13;
   localparam int TAB_AW   = $clog2(TABLE_DEPTH);
   localparam int COEF_W   = 18;
   localparam int ROW_W    = 3 * COEF_W;
   localparam int PROD_W   = COMP_W + 1 + COEF_W;
   localparam int SUM_W    = PROD_W + 2;
   localparam int PMUL_W   = COMP_W + ALPHA_W;
   localparam int NUM_W    = COMP_W + FRAC_BITS;
   localparam int REM_W    = ALPHA_W + 1;
   localparam int DIV_BITS_PER_STEP = 2;
   localparam int DIV_STEPS = COMP_W / DIV_BITS_PER_STEP;
   localparam int DIV_LAT   = DIV_STEPS + 1;
   localparam int CSR_IDX_W = 3;

   localparam logic [COMP_W-1:0] COMP_MAX = '1;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_IN_CURVE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_CURVE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MATRIX_EN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PREMULT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ROW0      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ROW1      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ROW2      = 3'd6;

   localparam logic [ROW_W-1:0] ROW0_RESET = ROW_W'(64'd16384);
   localparam logic [ROW_W-1:0] ROW1_RESET = ROW_W'(64'd4294967296);
   localparam logic [ROW_W-1:0] ROW2_RESET = ROW_W'(64'd1125899906842624);

   typedef enum logic [1:0] {
      KIND_PIXEL   = 2'd0,
      KIND_LIN_WR  = 2'd1,
      KIND_DLIN_WR = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef logic [2:0][COMP_W-1:0] comp3_type;

   // sideband that travels with every item
   typedef struct packed {
      logic                valid;
      kind_type            kind;
      logic                unpre;
      logic [ALPHA_W-1:0]  alpha;
      logic [TAB_AW-1:0]   idx;
      logic [COMP_W-1:0]   val;
   } side_type;

   function automatic logic [TAB_AW-1:0] sat_index(input logic [COMP_W-1:0] c);
      logic [TAB_AW-1:0] r;
      if (c > COMP_W'(TABLE_DEPTH - 1)) r = '1;
      else                              r = c[TAB_AW-1:0];
      return r;
   endfunction

endpackage

/* rtl/pcsp_div.sv */
// Pipelined restoring divider for unpremultiply, two quotient bits per stage.
module pcsp_div import pcsp_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic [NUM_W-1:0]   num_in,
   input  logic [ALPHA_W-1:0] den_in,
   output logic [COMP_W-1:0]  quo_out
);

   logic [REM_W-1:0]   rem_ff [DIV_STEPS+1];
   logic [COMP_W-1:0]  nlo_ff [DIV_STEPS+1];
   logic [COMP_W-1:0]  quo_ff [DIV_STEPS+1];
   logic [ALPHA_W-1:0] den_ff [DIV_STEPS+1];
   logic               sat_ff [DIV_STEPS+1];

   // quotient overflows 16 bits exactly when the top numerator bits reach the divisor
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= REM_W'(num_in[NUM_W-1 -: FRAC_BITS]);
         nlo_ff[0] <= num_in[COMP_W-1:0];
         quo_ff[0] <= '0;
         den_ff[0] <= den_in;
         sat_ff[0] <= ALPHA_W'(num_in[NUM_W-1 -: FRAC_BITS]) >= den_in;
      end
   end

   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
      logic [REM_W-1:0]  rem_in;
      logic [COMP_W-1:0] nlo_in;
      logic [COMP_W-1:0] quo_in;

      always_comb begin
         rem_in = rem_ff[s];
         nlo_in = nlo_ff[s];
         quo_in = quo_ff[s];
         for (int b = 0; b < DIV_BITS_PER_STEP; b++) begin
            rem_in = {rem_in[REM_W-2:0], nlo_in[COMP_W-1]};
            nlo_in = {nlo_in[COMP_W-2:0], 1'b0};
            if (rem_in >= REM_W'(den_ff[s])) begin
               rem_in = rem_in - REM_W'(den_ff[s]);
               quo_in = {quo_in[COMP_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_in[COMP_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s+1] <= rem_in;
            nlo_ff[s+1] <= nlo_in;
            quo_ff[s+1] <= quo_in;
            den_ff[s+1] <= den_ff[s];
            sat_ff[s+1] <= sat_ff[s];
         end
      end
   end

   assign quo_out = sat_ff[DIV_STEPS] ? COMP_MAX : quo_ff[DIV_STEPS];

endmodule

/* rtl/pcsp_lut.sv */
// Curve table: three copies written together, one read port per component.
module pcsp_lut import pcsp_pkg::*; (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     wr_en,
   input  logic [TAB_AW-1:0]        wr_addr,
   input  logic [COMP_W-1:0]        wr_data,
   input  logic [2:0][TAB_AW-1:0]   rd_addr,
   output comp3_type                rd_data
);

   logic [COMP_W-1:0] mem0 [TABLE_DEPTH];
   logic [COMP_W-1:0] mem1 [TABLE_DEPTH];
   logic [COMP_W-1:0] mem2 [TABLE_DEPTH];
   comp3_type         rd_ff;

   always_ff @(posedge clock) begin
      if (en && wr_en) begin
         mem0[wr_addr] <= wr_data;
         mem1[wr_addr] <= wr_data;
         mem2[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rd_ff[0] <= mem0[rd_addr[0]];
         rd_ff[1] <= mem1[rd_addr[1]];
         rd_ff[2] <= mem2[rd_addr[2]];
      end
   end

   assign rd_data = rd_ff;

endmodule

/* rtl/pixel_color_space_pipeline.sv */
// Top level of the pixel color pipeline: unpremultiply, curves, matrix, premultiply.
//
// Usage:
//  - req_ channel carries one item per handshake: a pixel (tuser = 0) or a
//    write of one linearize (tuser = 1) or delinearize (tuser = 2) table entry.
//    A pixel gives one rsp_ item; table writes and tuser = 3 give none.
//  - Table writes travel down the pipe and land at the stage that reads that
//    table, so every pixel sees exactly the writes accepted before it.
//  - csr_ channel writes the seven control registers; csr_ready is always high.
//    Write it only while the pipe is empty.
//  - Throughput: one item per clock while the output does not stall. The pipe
//    holds the eight two-bit divider stages of unpremultiply.
//  - All stages advance together; when rsp_tvalid is high and rsp_tready low the
//    whole pipe holds and req_tready drops. Nothing is lost or repeated.
//  - Reset clears all valid bits and loads the registers with identity matrix
//    and all features off. Table contents are undefined until written.
module pixel_color_space_pipeline import pcsp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // red[15:0] green[31:16] blue[47:32] alpha_in[60:48] entry_index[72:61]
   // entry_value[88:73], zero fill above
   input  logic [95:0]           req_tdata,
   // req_type[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // red_out[15:0] green_out[31:16] blue_out[47:32] alpha_out[60:48], zero fill
   output logic [63:0]           rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [ROW_W-1:0]      csr_data
);

   logic advance;

   logic                 in_curve_ff, out_curve_ff, matrix_en_ff, premult_ff;
   logic [2:0][ROW_W-1:0] row_ff;

   side_type  a_side_ff, a_side_in;
   comp3_type a_comp_ff;
   side_type  dv_side_ff [DIV_LAT];
   comp3_type dv_comp_ff [DIV_LAT];
   comp3_type quo;
   side_type  u_side_ff, l_side_ff, m1_side_ff, m2_side_ff, d_side_ff, p_side_ff;
   comp3_type u_comp_ff, u_comp_in, l_comp_ff, l_sel, m1_comp_ff, m2_comp_ff;
   comp3_type d_comp_ff, d_sel, p_comp_ff, mat_res, lin_q, dl_q, pre_res;
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic [2:0][PMUL_W-1:0]   p_prod_ff;
   logic [2:0][TAB_AW-1:0]   lin_addr, dl_addr;
   logic [COMP_W-1:0]        rsp_r_ff, rsp_g_ff, rsp_b_ff;
   logic [ALPHA_W-1:0]       rsp_a_ff;
   logic                     rsp_valid_ff;

   // hold the whole pipe while the output item waits
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_a_ff, rsp_b_ff, rsp_g_ff, rsp_r_ff};

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_curve_ff  <= 1'b0;
         out_curve_ff <= 1'b0;
         matrix_en_ff <= 1'b0;
         premult_ff   <= 1'b0;
         row_ff[0]    <= ROW0_RESET;
         row_ff[1]    <= ROW1_RESET;
         row_ff[2]    <= ROW2_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_IN_CURVE:  in_curve_ff  <= csr_data[0];
            REG_OUT_CURVE: out_curve_ff <= csr_data[0];
            REG_MATRIX_EN: matrix_en_ff <= csr_data[0];
            REG_PREMULT:   premult_ff   <= csr_data[0];
            REG_ROW0:      row_ff[0]    <= csr_data;
            REG_ROW1:      row_ff[1]    <= csr_data;
            REG_ROW2:      row_ff[2]    <= csr_data;
            default: ;
         endcase
      end
   end

   // input stage: unpack and decide on unpremultiply
   always_comb begin
      a_side_in.valid = req_tvalid;
      a_side_in.kind  = kind_type'(req_tuser);
      a_side_in.alpha = req_tdata[60:48];
      a_side_in.idx   = req_tdata[72:61];
      a_side_in.val   = req_tdata[88:73];
      a_side_in.unpre = premult_ff && (req_tdata[60:48] != '0) &&
                        (kind_type'(req_tuser) == KIND_PIXEL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_side_ff.valid <= 1'b0;
      end else if (advance) begin
         a_side_ff.valid <= a_side_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_side_ff.kind  <= a_side_in.kind;
         a_side_ff.alpha <= a_side_in.alpha;
         a_side_ff.idx   <= a_side_in.idx;
         a_side_ff.val   <= a_side_in.val;
         a_side_ff.unpre <= a_side_in.unpre;
         a_comp_ff[0]    <= req_tdata[15:0];
         a_comp_ff[1]    <= req_tdata[31:16];
         a_comp_ff[2]    <= req_tdata[47:32];
      end
   end

   // unpremultiply: (c << FRAC_BITS + alpha/2) / alpha
   for (genvar k = 0; k < 3; k++) begin : g_div
      pcsp_div u_div (
         .clock   (clock),
         .en      (advance),
         .num_in  ({a_comp_ff[k], {FRAC_BITS{1'b0}}} +
                   NUM_W'(a_side_ff.alpha[ALPHA_W-1:1])),
         .den_in  (a_side_ff.alpha),
         .quo_out (quo[k])
      );
   end

   // sideband delay line that runs beside the divider
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_LAT; s++) dv_side_ff[s] <= '0;
      end else if (advance) begin
         dv_side_ff[0] <= a_side_ff;
         for (int s = 1; s < DIV_LAT; s++) dv_side_ff[s] <= dv_side_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dv_comp_ff[0] <= a_comp_ff;
         for (int s = 1; s < DIV_LAT; s++) dv_comp_ff[s] <= dv_comp_ff[s-1];
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         u_comp_in[k] = dv_side_ff[DIV_LAT-1].unpre ? quo[k] : dv_comp_ff[DIV_LAT-1][k];
         lin_addr[k]  = sat_index(u_comp_ff[k]);
         dl_addr[k]   = sat_index(m2_comp_ff[k]);
      end
   end

   // linearize table, read and written at the same stage
   pcsp_lut u_lin (
      .clock   (clock),
      .en      (advance),
      .wr_en   (u_side_ff.valid && (u_side_ff.kind == KIND_LIN_WR)),
      .wr_addr (u_side_ff.idx),
      .wr_data (u_side_ff.val),
      .rd_addr (lin_addr),
      .rd_data (lin_q)
   );

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         l_sel[k] = in_curve_ff ? lin_q[k] : l_comp_ff[k];
      end
   end

   // matrix result: clamp negatives, round half up, saturate
   always_comb begin
      logic signed [SUM_W-1:0] sum;
      logic [SUM_W-1:0]        rnd;
      for (int j = 0; j < 3; j++) begin
         sum = SUM_W'(prod_ff[0][j]) + SUM_W'(prod_ff[1][j]) + SUM_W'(prod_ff[2][j]);
         rnd = (SUM_W'(sum) + SUM_W'(1 << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
         if (sum < 0)                  mat_res[j] = '0;
         else if (rnd > SUM_W'(COMP_MAX)) mat_res[j] = COMP_MAX;
         else                          mat_res[j] = rnd[COMP_W-1:0];
      end
   end

   // delinearize table
   pcsp_lut u_dlin (
      .clock   (clock),
      .en      (advance),
      .wr_en   (m2_side_ff.valid && (m2_side_ff.kind == KIND_DLIN_WR)),
      .wr_addr (m2_side_ff.idx),
      .wr_data (m2_side_ff.val),
      .rd_addr (dl_addr),
      .rd_data (dl_q)
   );

   always_comb begin
      logic [PMUL_W:0] rnd;
      for (int k = 0; k < 3; k++) begin
         d_sel[k] = out_curve_ff ? dl_q[k] : d_comp_ff[k];
         rnd = ((PMUL_W+1)'(p_prod_ff[k]) + (PMUL_W+1)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
         if (rnd > (PMUL_W+1)'(COMP_MAX)) pre_res[k] = COMP_MAX;
         else                             pre_res[k] = rnd[COMP_W-1:0];
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         u_side_ff.valid  <= 1'b0;
         l_side_ff.valid  <= 1'b0;
         m1_side_ff.valid <= 1'b0;
         m2_side_ff.valid <= 1'b0;
         d_side_ff.valid  <= 1'b0;
         p_side_ff.valid  <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else if (advance) begin
         u_side_ff.valid  <= dv_side_ff[DIV_LAT-1].valid;
         l_side_ff.valid  <= u_side_ff.valid;
         m1_side_ff.valid <= l_side_ff.valid;
         m2_side_ff.valid <= m1_side_ff.valid;
         d_side_ff.valid  <= m2_side_ff.valid;
         p_side_ff.valid  <= d_side_ff.valid;
         // drop table writes and unknown kinds here
         rsp_valid_ff     <= p_side_ff.valid && (p_side_ff.kind == KIND_PIXEL);
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         u_side_ff.kind  <= dv_side_ff[DIV_LAT-1].kind;
         u_side_ff.unpre <= dv_side_ff[DIV_LAT-1].unpre;
         u_side_ff.alpha <= dv_side_ff[DIV_LAT-1].alpha;
         u_side_ff.idx   <= dv_side_ff[DIV_LAT-1].idx;
         u_side_ff.val   <= dv_side_ff[DIV_LAT-1].val;
         u_comp_ff       <= u_comp_in;

         l_side_ff.kind  <= u_side_ff.kind;
         l_side_ff.unpre <= u_side_ff.unpre;
         l_side_ff.alpha <= u_side_ff.alpha;
         l_side_ff.idx   <= u_side_ff.idx;
         l_side_ff.val   <= u_side_ff.val;
         l_comp_ff       <= u_comp_ff;

         m1_side_ff.kind  <= l_side_ff.kind;
         m1_side_ff.unpre <= l_side_ff.unpre;
         m1_side_ff.alpha <= l_side_ff.alpha;
         m1_side_ff.idx   <= l_side_ff.idx;
         m1_side_ff.val   <= l_side_ff.val;
         m1_comp_ff       <= l_sel;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[i][j] <= $signed({1'b0, l_sel[i]}) *
                                $signed(row_ff[i][COEF_W*j +: COEF_W]);
            end
         end

         m2_side_ff.kind  <= m1_side_ff.kind;
         m2_side_ff.unpre <= m1_side_ff.unpre;
         m2_side_ff.alpha <= m1_side_ff.alpha;
         m2_side_ff.idx   <= m1_side_ff.idx;
         m2_side_ff.val   <= m1_side_ff.val;
         m2_comp_ff       <= matrix_en_ff ? mat_res : m1_comp_ff;

         d_side_ff.kind  <= m2_side_ff.kind;
         d_side_ff.unpre <= m2_side_ff.unpre;
         d_side_ff.alpha <= m2_side_ff.alpha;
         d_side_ff.idx   <= m2_side_ff.idx;
         d_side_ff.val   <= m2_side_ff.val;
         d_comp_ff       <= m2_comp_ff;

         p_side_ff.kind  <= d_side_ff.kind;
         p_side_ff.unpre <= d_side_ff.unpre;
         p_side_ff.alpha <= d_side_ff.alpha;
         p_side_ff.idx   <= d_side_ff.idx;
         p_side_ff.val   <= d_side_ff.val;
         p_comp_ff       <= d_sel;
         for (int k = 0; k < 3; k++) begin
            p_prod_ff[k] <= PMUL_W'(d_sel[k]) * PMUL_W'(d_side_ff.alpha);
         end

         // premultiply only where unpremultiply was done
         rsp_r_ff <= p_side_ff.unpre ? pre_res[0] : p_comp_ff[0];
         rsp_g_ff <= p_side_ff.unpre ? pre_res[1] : p_comp_ff[1];
         rsp_b_ff <= p_side_ff.unpre ? pre_res[2] : p_comp_ff[2];
         rsp_a_ff <= p_side_ff.alpha;
      end
   end

endmodule

/* tb/tb.sv */
// Self-checking testbench for the pixel color space pipeline.
module tb import pcsp_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 40;       // well past the pipeline latency
   localparam longint CYCLE_LIMIT = 3000000;
   localparam logic [COEF_W-1:0] COEF_POS_MAX = 18'h1FFFF;
   localparam logic [COEF_W-1:0] COEF_NEG_MAX = 18'h20000;
   localparam logic [COEF_W-1:0] COEF_ONE     = 18'h04000;
   localparam logic [COEF_W-1:0] COEF_ZERO    = 18'h00000;
   // register index past the end of the list
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic [COMP_W-1:0]  red;
      logic [COMP_W-1:0]  green;
      logic [COMP_W-1:0]  blue;
      logic [ALPHA_W-1:0] alpha;
   } pixel_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [95:0]          req_tdata = '0;
   logic [1:0]           req_tuser = KIND_PIXEL;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [63:0]          rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = REG_IN_CURVE;
   logic [ROW_W-1:0]     csr_data = '0;

   pixel_color_space_pipeline i_dut (.*);

   always #1 clock = ~clock;

   // Shadow copy of the pipeline settings and curve tables.
   logic [COMP_W-1:0] lin_curve [TABLE_DEPTH];
   logic [COMP_W-1:0] delin_curve [TABLE_DEPTH];
   logic              use_in_curve, use_out_curve, use_matrix, use_premult;
   logic [ROW_W-1:0]  matrix_rows [3];

   pixel_type expected_pixels [$];
   int        mismatches = 0;
   longint    cycle_count = 0;
   int        burst_left = 0;
   bit        bursty = 1'b1;

   function automatic longint comp_clamp(longint v);
      return (v > longint'(COMP_MAX)) ? longint'(COMP_MAX) : v;
   endfunction

   function automatic longint table_slot(longint c);
      return (c > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : c;
   endfunction

   // Compute the transformed pixel from the shadow state.
   function automatic pixel_type transform_pixel(logic [COMP_W-1:0] r, logic [COMP_W-1:0] g,
                                                 logic [COMP_W-1:0] b, logic [ALPHA_W-1:0] a);
      longint    c [3];
      longint    m [3];
      longint    sum, coef;
      bit        assoc;
      pixel_type p;
      c[0] = r; c[1] = g; c[2] = b;
      assoc = use_premult && (a != 0);
      for (int i = 0; i < 3; i++) begin
         if (assoc) c[i] = comp_clamp(((c[i] << FRAC_BITS) + (a >> 1)) / a);
         if (use_in_curve) c[i] = lin_curve[table_slot(c[i])];
      end
      if (use_matrix) begin
         for (int j = 0; j < 3; j++) begin
            sum = 0;
            for (int i = 0; i < 3; i++) begin
               coef = longint'($signed(matrix_rows[i][COEF_W*j +: COEF_W]));
               sum += c[i] * coef;
            end
            m[j] = (sum < 0) ? 0 : comp_clamp((sum + (1 << (COEF_FRAC_BITS - 1)))
                                              >>> COEF_FRAC_BITS);
         end
         c = m;
      end
      for (int i = 0; i < 3; i++) begin
         if (use_out_curve) c[i] = delin_curve[table_slot(c[i])];
         if (assoc) c[i] = comp_clamp((c[i] * a + (1 << (FRAC_BITS - 1))) >> FRAC_BITS);
      end
      p.red = COMP_W'(c[0]); p.green = COMP_W'(c[1]); p.blue = COMP_W'(c[2]); p.alpha = a;
      return p;
   endfunction

   // Receiver: drive rsp_tready from a randomly chosen stall pattern that changes over the run.
   int stall_mode = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0, 1: begin
            rsp_tready <= 1'b1;
         end
         2: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 3) == 0);
         end
      endcase
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // Outputs are stable at the falling edge; a handshake seen here completes
   // at the next rising edge.
   always @(negedge clock) begin
      pixel_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32], rsp_tdata[60:48]};
         if (expected_pixels.size() == 0) begin
            $error("unexpected pixel %h", got);
            mismatches++;
         end else begin
            want = expected_pixels.pop_front();
            if (got.red != want.red) begin
               $error("red_out: expected %0d actual %0d", want.red, got.red);
               mismatches++;
            end
            if (got.green != want.green) begin
               $error("green_out: expected %0d actual %0d", want.green, got.green);
               mismatches++;
            end
            if (got.blue != want.blue) begin
               $error("blue_out: expected %0d actual %0d", want.blue, got.blue);
               mismatches++;
            end
            if (got.alpha != want.alpha) begin
               $error("alpha_out: expected %0d actual %0d", want.alpha, got.alpha);
               mismatches++;
            end
         end
      end
   end

   // Send one item; valid stays high afterward unless a gap follows.
   task automatic send_item(kind_type kind, logic [COMP_W-1:0] r, logic [COMP_W-1:0] g,
                            logic [COMP_W-1:0] b, logic [ALPHA_W-1:0] a,
                            logic [TAB_AW-1:0] idx, logic [COMP_W-1:0] val);
      int gap;
      if (bursty && burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (burst_left > 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, val, idx, a, b, g, r};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      case (kind)
         KIND_PIXEL: begin
            expected_pixels.push_back(transform_pixel(r, g, b, a));
         end
         KIND_LIN_WR: begin
            lin_curve[idx] = val;
         end
         KIND_DLIN_WR: begin
            delin_curve[idx] = val;
         end
         default: begin
         end
      endcase
   endtask

   task automatic send_pixel(logic [COMP_W-1:0] r, logic [COMP_W-1:0] g,
                             logic [COMP_W-1:0] b, logic [ALPHA_W-1:0] a);
      send_item(KIND_PIXEL, r, g, b, a, TAB_AW'($urandom), COMP_W'($urandom));
   endtask

   // Hold until every pixel is out and table writes have settled.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register, then drop csr_valid and update the shadow copy.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [ROW_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_IN_CURVE:  use_in_curve  = value[0];
         REG_OUT_CURVE: use_out_curve = value[0];
         REG_MATRIX_EN: use_matrix    = value[0];
         REG_PREMULT:   use_premult   = value[0];
         REG_ROW0:      matrix_rows[0] = value;
         REG_ROW1:      matrix_rows[1] = value;
         REG_ROW2:      matrix_rows[2] = value;
         default: begin
         end
      endcase
   endtask

   task automatic set_modes(bit in_c, bit out_c, bit mat, bit pre);
      write_reg(REG_IN_CURVE, ROW_W'(in_c));
      write_reg(REG_OUT_CURVE, ROW_W'(out_c));
      write_reg(REG_MATRIX_EN, ROW_W'(mat));
      write_reg(REG_PREMULT, ROW_W'(pre));
   endtask

   task automatic set_matrix(logic [ROW_W-1:0] r0, logic [ROW_W-1:0] r1, logic [ROW_W-1:0] r2);
      write_reg(REG_ROW0, r0);
      write_reg(REG_ROW1, r1);
      write_reg(REG_ROW2, r2);
   endtask

   function automatic logic [COEF_W-1:0] pick_coef();
      case ($urandom_range(0, 5))
         0: return COEF_POS_MAX;
         1: return COEF_NEG_MAX;
         2: return COEF_W'($urandom);
         default: return COEF_W'($urandom_range(0, 24576) - 4096);
      endcase
   endfunction

   function automatic logic [ROW_W-1:0] pick_row();
      return {pick_coef(), pick_coef(), pick_coef()};
   endfunction

   function automatic logic [COMP_W-1:0] pick_comp();
      case ($urandom_range(0, 3))
         0: return COMP_W'($urandom);
         1: return COMP_W'($urandom_range(0, 4096));
         default: return COMP_W'($urandom_range(0, 8191));
      endcase
   endfunction

   function automatic logic [ALPHA_W-1:0] pick_alpha();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return ALPHA_W'(1 << FRAC_BITS);
         2: return ALPHA_W'($urandom);
         default: return ALPHA_W'($urandom_range(1, 4096));
      endcase
   endfunction

   // Pass-through defaults, extremes and ignored items, then identity matrix with unpremultiply, tables still empty.
   task automatic test_reset_defaults();
      send_pixel('0, '0, '0, '0);
      send_pixel(COMP_MAX, COMP_MAX, COMP_MAX, '1);
      send_pixel(16'h1000, 16'h0800, 16'hFFFF, 13'd4096);
      send_item(KIND_NONE, 16'h1234, 16'h5678, 16'h9ABC, 13'd77, '1, '1);
      send_pixel(16'hAAAA, 16'h5555, 16'h0001, 13'h0AAA);
      drain();
      write_reg(REG_UNUSED, '1);
      set_modes(1'b0, 1'b0, 1'b1, 1'b1);
      send_pixel(COMP_MAX, 16'd0, 16'd4096, 13'd0);  // zero alpha: no unpremultiply
      send_pixel(16'd100, 16'd200, 16'd300, 13'd1);  // tiny alpha saturates
      send_pixel(16'd4096, 16'd8192, 16'd2048, 13'h1FFF); // alpha above one
      send_pixel(16'd2048, 16'd2048, 16'd2048, 13'd2048);
      drain();
   endtask

   // Fill both curves completely so no lookup ever reads an unwritten entry.
   task automatic test_fill_tables();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         send_item(KIND_LIN_WR, '0, '0, '0, '0, TAB_AW'(i),
                   (i % 7 == 0) ? COMP_W'($urandom) : COMP_W'((i * i) >> 10));
         send_item(KIND_DLIN_WR, '0, '0, '0, '0, TAB_AW'(i),
                   (i == TABLE_DEPTH - 1) ? COMP_MAX : COMP_W'($urandom_range(0, 4 * i + 3)));
      end
      drain();
   endtask

   // Every stage on with extreme coefficients and table extremes.
   task automatic test_matrix_extremes();
      set_modes(1'b1, 1'b1, 1'b1, 1'b1);
      set_matrix({3{COEF_POS_MAX}}, {3{COEF_POS_MAX}}, {3{COEF_POS_MAX}});
      send_pixel(COMP_MAX, COMP_MAX, COMP_MAX, 13'd4096);
      send_pixel(16'd4095, 16'd0, 16'd4096, 13'd4096);
      drain();
      set_matrix({3{COEF_NEG_MAX}}, {3{COEF_NEG_MAX}}, {3{COEF_NEG_MAX}});
      send_pixel(COMP_MAX, 16'd1, 16'd7, 13'd4096);
      drain();
      set_matrix({COEF_NEG_MAX, COEF_ONE, COEF_POS_MAX}, '0,
                 {COEF_ONE, COEF_ZERO, COEF_NEG_MAX});
      send_pixel(16'd4000, 16'd1234, 16'd300, 13'd3000);
      send_item(KIND_LIN_WR, '0, '0, '0, '0, '1, COMP_MAX);
      send_item(KIND_DLIN_WR, '0, '0, '0, '0, '0, '0);
      send_pixel(COMP_MAX, 16'd0, 16'd4095, 13'd0);
      drain();
      set_matrix(ROW0_RESET, ROW1_RESET, ROW2_RESET);
   endtask

   // Random phases, each under its own settings.
   task automatic test_random_phases();
      int kind_pick;
      for (int ph = 0; ph < 10; ph++) begin
         bursty = (ph % 3 != 2);
         set_modes($urandom_range(0, 1), $urandom_range(0, 1),
                   $urandom_range(0, 1), (ph < 2) ? 1'b1 : $urandom_range(0, 1));
         if (ph > 0) set_matrix(pick_row(), pick_row(), pick_row());
         for (int n = 0; n < 125; n++) begin
            kind_pick = $urandom_range(0, 19);
            if (kind_pick < 16) begin
               send_pixel(pick_comp(), pick_comp(), pick_comp(), pick_alpha());
            end else if (kind_pick < 18) begin
               send_item(kind_type'($urandom_range(1, 2)), COMP_W'($urandom),
                         COMP_W'($urandom), COMP_W'($urandom), ALPHA_W'($urandom),
                         TAB_AW'($urandom), COMP_W'($urandom));
            end else begin
               send_item(KIND_NONE, COMP_W'($urandom), COMP_W'($urandom),
                         COMP_W'($urandom), ALPHA_W'($urandom), TAB_AW'($urandom),
                         COMP_W'($urandom));
            end
            if (ph == 4 && n == 60) drain();  // pause until all results are back
         end
         drain();
      end
   endtask

   initial begin
      use_in_curve = 1'b0; use_out_curve = 1'b0; use_matrix = 1'b0; use_premult = 1'b0;
      matrix_rows[0] = ROW0_RESET; matrix_rows[1] = ROW1_RESET; matrix_rows[2] = ROW2_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_fill_tables();
      test_matrix_extremes();
      test_random_phases();
      drain();
      if (mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule
